/* rtl/sgfc_pkg.sv */
package sgfc_pkg;

  // Motor owner codes
  typedef enum logic [1:0] {
    OWN_NONE   = 2'd0,
    OWN_MANUAL = 2'd1,
    OWN_AUTO   = 2'd2
  } owner_t;

  // Register map (word index on the APB port)
  typedef enum logic [2:0] {
    REG_BALL_THRESHOLD   = 3'd0,
    REG_PUNCHER_HOLD     = 3'd1,
    REG_RUMBLE_AFTER     = 3'd2,
    REG_OVERFLOW_TIMEOUT = 3'd3,
    REG_LONG_PRESS       = 3'd4,
    REG_SPEED_IN         = 3'd5,
    REG_SPEED_OUT        = 3'd6,
    REG_SPEED_OVERFLOW   = 3'd7
  } reg_index_t;

  localparam int TICK_W  = 12;
  localparam int THR_W   = 12;
  localparam int VIN_W   = 10;
  localparam int VEL_W   = 11;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [THR_W-1:0]         BALL_THRESHOLD_RST   = 12'd2000;
  localparam logic [TICK_W-1:0]        PUNCHER_HOLD_RST     = 12'd250;
  localparam logic [TICK_W-1:0]        RUMBLE_AFTER_RST     = 12'd100;
  localparam logic [TICK_W-1:0]        OVERFLOW_TIMEOUT_RST = 12'd100;
  localparam logic [TICK_W-1:0]        LONG_PRESS_RST       = 12'd10;
  localparam logic [VIN_W-1:0]         SPEED_IN_RST         = 10'd600;
  localparam logic signed [VEL_W-1:0]  SPEED_OUT_RST        = -11'sd600;
  localparam logic signed [VEL_W-1:0]  SPEED_OVERFLOW_RST   = -11'sd300;

endpackage

/* rtl/sensor_gated_feeder_control.sv */
// Channel   Direction  Handshake                 Payload
// tick      in         tick_valid / tick_stall   4 button levels, 4 sensor samples
// result    out        result_valid / result_stall  velocity, owner, 6 flags
// config    in         APB psel/penable/pwrite   8 registers at 4*index
//
// One tick is taken per cycle unless tick_stall holds it off; a tick passes through the input
// register, then the result register, with a single pass of button, sensor and speed logic.
// The result register lets a new tick enter while a finished result is stalled.
// rst is synchronous: it clears the valid flags and control state and reloads the register defaults.
// tick_stall rises only when the input register is full and the result is stalled.
module sensor_gated_feeder_control #(
  parameter int COUNT_WIDTH  = 12,
  parameter int SENSOR_WIDTH = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // tick channel
  input  logic                                 tick_valid,
  output logic                                 tick_stall,
  input  logic                                 combo_button,
  input  logic                                 out_button,
  input  logic                                 in_button,
  input  logic                                 toggle_button,
  input  logic [SENSOR_WIDTH-1:0]              puncher_level,
  input  logic [SENSOR_WIDTH-1:0]              overflow_level,
  input  logic [SENSOR_WIDTH-1:0]              bottom_level,
  input  logic [SENSOR_WIDTH-1:0]              top_level,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [sgfc_pkg::VEL_W-1:0]    motor_velocity,
  output logic [1:0]                           owner,
  output logic                                 auto_enabled,
  output logic                                 ball_seen_puncher,
  output logic                                 ball_at_puncher,
  output logic                                 ball_at_overflow,
  output logic                                 ball_in_feed,
  output logic                                 rumble,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sgfc_pkg::ADDR_W-1:0]          paddr,
  input  logic [sgfc_pkg::DATA_W-1:0]          pwdata,
  output logic [sgfc_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  localparam int CMP_W  = (COUNT_WIDTH > sgfc_pkg::TICK_W) ? COUNT_WIDTH : sgfc_pkg::TICK_W;
  localparam int SCMP_W = (SENSOR_WIDTH > sgfc_pkg::THR_W) ? SENSOR_WIDTH : sgfc_pkg::THR_W;
  localparam int VW     = sgfc_pkg::VEL_W;
  localparam int NW     = sgfc_pkg::VIN_W;

  // configuration registers
  logic [sgfc_pkg::THR_W-1:0]  ball_threshold;
  logic [sgfc_pkg::TICK_W-1:0] puncher_hold_ticks;
  logic [sgfc_pkg::TICK_W-1:0] rumble_after_ticks;
  logic [sgfc_pkg::TICK_W-1:0] overflow_timeout_ticks;
  logic [sgfc_pkg::TICK_W-1:0] long_press_ticks;
  logic [NW-1:0]               speed_in;
  logic signed [VW-1:0]        speed_out;
  logic signed [VW-1:0]        speed_overflow;

  logic                        cfg_write;
  sgfc_pkg::reg_index_t        cfg_sel;

  // control state
  sgfc_pkg::owner_t            owner_reg, owner_reg_next;
  logic signed [VW-1:0]        speed_reg, speed_reg_next;
  logic                        auto_on, auto_on_next;
  logic                        auto_was_on, auto_was_on_next;
  logic                        overflow_mode, overflow_mode_next;
  logic [COUNT_WIDTH-1:0]      overflow_count, overflow_count_next;
  logic [COUNT_WIDTH-1:0]      puncher_count, puncher_count_next;
  logic [COUNT_WIDTH-1:0]      combo_count, combo_count_next;
  logic                        puncher_latch, puncher_latch_next;
  logic                        rumble_reg, rumble_reg_next;
  logic [3:0]                  last_buttons;

  // input register
  logic                        s1_valid;
  logic [3:0]                  s1_buttons;
  logic [SENSOR_WIDTH-1:0]     s1_puncher, s1_overflow, s1_bottom, s1_top;

  logic                        tick_accept;
  logic                        advance;

  // per-tick combinational results
  logic                        seen, over_ball, bot_ball, top_ball, feed_ball;
  logic signed [VW-1:0]        vel;
  logic [NW+2:0]               speed_in_x7;
  logic signed [VW-1:0]        speed_in_full, speed_in_78, speed_in_14;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = sgfc_pkg::reg_index_t'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ball_threshold         <= sgfc_pkg::BALL_THRESHOLD_RST;
      puncher_hold_ticks     <= sgfc_pkg::PUNCHER_HOLD_RST;
      rumble_after_ticks     <= sgfc_pkg::RUMBLE_AFTER_RST;
      overflow_timeout_ticks <= sgfc_pkg::OVERFLOW_TIMEOUT_RST;
      long_press_ticks       <= sgfc_pkg::LONG_PRESS_RST;
      speed_in               <= sgfc_pkg::SPEED_IN_RST;
      speed_out              <= sgfc_pkg::SPEED_OUT_RST;
      speed_overflow         <= sgfc_pkg::SPEED_OVERFLOW_RST;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        sgfc_pkg::REG_BALL_THRESHOLD:   ball_threshold         <= pwdata[11:0];
        sgfc_pkg::REG_PUNCHER_HOLD:     puncher_hold_ticks     <= pwdata[11:0];
        sgfc_pkg::REG_RUMBLE_AFTER:     rumble_after_ticks     <= pwdata[11:0];
        sgfc_pkg::REG_OVERFLOW_TIMEOUT: overflow_timeout_ticks <= pwdata[11:0];
        sgfc_pkg::REG_LONG_PRESS:       long_press_ticks       <= pwdata[11:0];
        sgfc_pkg::REG_SPEED_IN:         speed_in               <= pwdata[NW-1:0];
        sgfc_pkg::REG_SPEED_OUT:        speed_out              <= $signed(pwdata[VW-1:0]);
        sgfc_pkg::REG_SPEED_OVERFLOW:   speed_overflow         <= $signed(pwdata[VW-1:0]);
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (cfg_sel)
      sgfc_pkg::REG_BALL_THRESHOLD:   prdata = 32'(ball_threshold);
      sgfc_pkg::REG_PUNCHER_HOLD:     prdata = 32'(puncher_hold_ticks);
      sgfc_pkg::REG_RUMBLE_AFTER:     prdata = 32'(rumble_after_ticks);
      sgfc_pkg::REG_OVERFLOW_TIMEOUT: prdata = 32'(overflow_timeout_ticks);
      sgfc_pkg::REG_LONG_PRESS:       prdata = 32'(long_press_ticks);
      sgfc_pkg::REG_SPEED_IN:         prdata = 32'(speed_in);
      sgfc_pkg::REG_SPEED_OUT:        prdata = 32'(unsigned'(32'(speed_out)));
      sgfc_pkg::REG_SPEED_OVERFLOW:   prdata = 32'(unsigned'(32'(speed_overflow)));
      default:                        prdata = '0;
    endcase
  end

  // handshake: the input register drains whenever the result register can load
  assign advance     = s1_valid && !(result_valid && result_stall);
  assign tick_stall  = s1_valid && result_valid && result_stall;
  assign tick_accept = tick_valid && !tick_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      s1_buttons  <= {toggle_button, in_button, out_button, combo_button};
      s1_puncher  <= puncher_level;
      s1_overflow <= overflow_level;
      s1_bottom   <= bottom_level;
      s1_top      <= top_level;
    end
  end

  // reduced intake speeds: seven eighths and one quarter, rounded down
  assign speed_in_x7   = {speed_in, 3'b000} - {3'b000, speed_in};
  assign speed_in_full = $signed({1'b0, speed_in});
  assign speed_in_78   = $signed({1'b0, speed_in_x7[NW+2:3]});
  assign speed_in_14   = $signed({3'b000, speed_in[NW-1:2]});

  // buttons, sensors and automatic speed for the tick in the input register
  always_comb begin
    logic c_now, o_now, i_now, t_now;
    logic c_was, o_was, i_was, t_was;

    c_now = s1_buttons[0];
    o_now = s1_buttons[1];
    i_now = s1_buttons[2];
    t_now = s1_buttons[3];
    c_was = last_buttons[0];
    o_was = last_buttons[1];
    i_was = last_buttons[2];
    t_was = last_buttons[3];

    owner_reg_next      = owner_reg;
    speed_reg_next      = speed_reg;
    auto_on_next        = auto_on;
    auto_was_on_next    = auto_was_on;
    overflow_mode_next  = overflow_mode;
    overflow_count_next = overflow_count;
    puncher_count_next  = puncher_count;
    combo_count_next    = combo_count;
    puncher_latch_next  = puncher_latch;
    rumble_reg_next     = rumble_reg;

    // combo: short press toggles auto, long hold runs reverse
    if (c_now != c_was) begin
      if (!c_now) begin
        if (CMP_W'(combo_count) <= CMP_W'(long_press_ticks)) begin
          if (auto_on_next) begin
            auto_was_on_next = 1'b1;
            auto_on_next     = 1'b0;
            owner_reg_next   = sgfc_pkg::OWN_NONE;
          end else begin
            auto_was_on_next = 1'b0;
            auto_on_next     = 1'b1;
            owner_reg_next   = sgfc_pkg::OWN_AUTO;
          end
        end else begin
          owner_reg_next = sgfc_pkg::OWN_NONE;
          speed_reg_next = '0;
        end
        combo_count_next = '0;
      end
    end else if (c_now) begin
      if (CMP_W'(combo_count) > CMP_W'(long_press_ticks)) begin
        owner_reg_next = sgfc_pkg::OWN_MANUAL;
        speed_reg_next = speed_out;
      end
      if (combo_count != '1) combo_count_next = combo_count + COUNT_WIDTH'(1);
    end

    // feed out button
    if (o_now != o_was) begin
      owner_reg_next = o_now ? sgfc_pkg::OWN_MANUAL : sgfc_pkg::OWN_NONE;
    end else if (o_now) begin
      speed_reg_next = speed_out;
    end

    // feed in button
    if (i_now != i_was) begin
      owner_reg_next = i_now ? sgfc_pkg::OWN_MANUAL : sgfc_pkg::OWN_NONE;
    end else if (i_now) begin
      speed_reg_next = speed_in_full;
    end

    // toggle button rising edge
    if (t_now && !t_was) begin
      if (auto_on_next) begin
        auto_was_on_next = 1'b1;
        auto_on_next     = 1'b0;
        owner_reg_next   = sgfc_pkg::OWN_NONE;
      end else begin
        auto_was_on_next = 1'b0;
        auto_on_next     = 1'b1;
        owner_reg_next   = sgfc_pkg::OWN_AUTO;
      end
    end

    // ball flags
    seen      = SCMP_W'(s1_puncher)  < SCMP_W'(ball_threshold);
    over_ball = SCMP_W'(s1_overflow) < SCMP_W'(ball_threshold);
    bot_ball  = SCMP_W'(s1_bottom)   < SCMP_W'(ball_threshold);
    top_ball  = SCMP_W'(s1_top)      < SCMP_W'(ball_threshold);
    feed_ball = bot_ball || top_ball;

    // puncher latch with hold timeout and rumble
    if (seen) begin
      puncher_count_next = '0;
      puncher_latch_next = 1'b1;
      rumble_reg_next    = 1'b0;
    end else begin
      if (CMP_W'(puncher_count) > CMP_W'(puncher_hold_ticks)) begin
        puncher_latch_next = 1'b0;
      end else if (CMP_W'(puncher_count) > CMP_W'(rumble_after_ticks)) begin
        rumble_reg_next = 1'b1;
      end
      if (puncher_count != '1) puncher_count_next = puncher_count + COUNT_WIDTH'(1);
    end

    // automatic speed
    if (owner_reg_next == sgfc_pkg::OWN_AUTO) begin
      if (auto_on_next) begin
        auto_was_on_next = 1'b1;
        if (overflow_mode) begin
          speed_reg_next = speed_overflow;
          if (over_ball) begin
            overflow_count_next = '0;
          end else if (feed_ball ||
                       CMP_W'(overflow_count) > CMP_W'(overflow_timeout_ticks)) begin
            overflow_mode_next = 1'b0;
          end else if (overflow_count != '1) begin
            overflow_count_next = overflow_count + COUNT_WIDTH'(1);
          end
        end else if (!puncher_latch_next) begin
          speed_reg_next = speed_in_full;
        end else if (over_ball) begin
          overflow_mode_next = 1'b1;
          speed_reg_next     = speed_overflow;
        end else if (!top_ball) begin
          speed_reg_next = bot_ball ? speed_in_14 : speed_in_78;
        end else begin
          speed_reg_next = '0;
        end
      end else if (auto_was_on_next) begin
        speed_reg_next   = '0;
        auto_was_on_next = 1'b0;
      end
    end

    vel = (owner_reg_next == sgfc_pkg::OWN_NONE) ? '0 : speed_reg_next;
  end

  // state update on each transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      owner_reg      <= sgfc_pkg::OWN_NONE;
      speed_reg      <= '0;
      auto_on        <= 1'b0;
      auto_was_on    <= 1'b0;
      overflow_mode  <= 1'b0;
      overflow_count <= '0;
      puncher_count  <= '0;
      combo_count    <= '0;
      puncher_latch  <= 1'b0;
      rumble_reg     <= 1'b0;
      last_buttons   <= '0;
    end else if (advance) begin
      owner_reg      <= owner_reg_next;
      speed_reg      <= speed_reg_next;
      auto_on        <= auto_on_next;
      auto_was_on    <= auto_was_on_next;
      overflow_mode  <= overflow_mode_next;
      overflow_count <= overflow_count_next;
      puncher_count  <= puncher_count_next;
      combo_count    <= combo_count_next;
      puncher_latch  <= puncher_latch_next;
      rumble_reg     <= rumble_reg_next;
      last_buttons   <= s1_buttons;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      motor_velocity    <= vel;
      owner             <= owner_reg_next;
      auto_enabled      <= auto_on_next;
      ball_seen_puncher <= seen;
      ball_at_puncher   <= puncher_latch_next;
      ball_at_overflow  <= over_ball;
      ball_in_feed      <= feed_ball;
      rumble            <= rumble_reg_next;
    end
  end

endmodule

/* rtl/sgfc_checker.sv */
module sgfc_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input logic signed [10:0] motor_velocity,
  input logic [1:0]        owner,
  input logic              auto_enabled,
  input logic              ball_seen_puncher,
  input logic              ball_at_puncher,
  input logic              rumble
);

  // a stalled result holds until its transfer
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(motor_velocity) && $stable(owner))
    else $error("stalled result changed");

  // no owner, no motion
  a_idle_motor: assert property (@(posedge clk) disable iff (rst)
    result_valid && owner == sgfc_pkg::OWN_NONE |-> motor_velocity == 11'sd0)
    else $error("motor moves without owner");

  // automatic ownership only while automatic feeding is on
  a_auto_owner: assert property (@(posedge clk) disable iff (rst)
    result_valid && owner == sgfc_pkg::OWN_AUTO |-> auto_enabled)
    else $error("auto owner while auto disabled");

  // a ball at the puncher sets the latch and clears rumble
  a_puncher_latch: assert property (@(posedge clk) disable iff (rst)
    result_valid && ball_seen_puncher |-> ball_at_puncher && !rumble)
    else $error("puncher latch or rumble wrong");

endmodule

bind sensor_gated_feeder_control sgfc_checker u_sgfc_checker (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .motor_velocity   (motor_velocity),
  .owner            (owner),
  .auto_enabled     (auto_enabled),
  .ball_seen_puncher(ball_seen_puncher),
  .ball_at_puncher  (ball_at_puncher),
  .rumble           (rumble)
);

/* test/sensor_gated_feeder_control_tb.sv */
module sensor_gated_feeder_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SENSOR_W        = 12;
  localparam int RANDOM_PHASES   = 6;
  localparam int TICKS_PER_PHASE = 110;
  localparam int SOAK_TICKS      = 100;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int HOLD_OFF_AFTER  = 300;
  localparam int SETTLE_CYCLES   = 4;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic                combo;
    logic                feed_out;
    logic                feed_in;
    logic                toggle;
    logic [SENSOR_W-1:0] puncher;
    logic [SENSOR_W-1:0] overflow;
    logic [SENSOR_W-1:0] bottom;
    logic [SENSOR_W-1:0] top;
  } tick_t;

  typedef struct packed {
    logic signed [sgfc_pkg::VEL_W-1:0] velocity;
    sgfc_pkg::owner_t                  own;
    logic                              auto_en;
    logic                              seen;
    logic                              at_puncher;
    logic                              at_overflow;
    logic                              in_feed;
    logic                              rumble_on;
  } motor_cmd_t;

  logic clk;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic combo_button = 1'b0;
  logic out_button = 1'b0;
  logic in_button = 1'b0;
  logic toggle_button = 1'b0;
  logic [SENSOR_W-1:0] puncher_level = '0;
  logic [SENSOR_W-1:0] overflow_level = '0;
  logic [SENSOR_W-1:0] bottom_level = '0;
  logic [SENSOR_W-1:0] top_level = '0;
  logic result_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sgfc_pkg::ADDR_W-1:0] paddr = '0;
  logic [sgfc_pkg::DATA_W-1:0] pwdata = '0;

  wire tick_stall;
  wire result_valid;
  wire signed [sgfc_pkg::VEL_W-1:0] motor_velocity;
  wire [1:0] owner;
  wire auto_enabled, ball_seen_puncher, ball_at_puncher, ball_at_overflow;
  wire ball_in_feed, rumble;
  wire [sgfc_pkg::DATA_W-1:0] prdata;
  wire pready;

  sensor_gated_feeder_control DUT (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_stall(tick_stall),
    .combo_button(combo_button), .out_button(out_button),
    .in_button(in_button), .toggle_button(toggle_button),
    .puncher_level(puncher_level), .overflow_level(overflow_level),
    .bottom_level(bottom_level), .top_level(top_level),
    .result_valid(result_valid), .result_stall(result_stall),
    .motor_velocity(motor_velocity), .owner(owner), .auto_enabled(auto_enabled),
    .ball_seen_puncher(ball_seen_puncher), .ball_at_puncher(ball_at_puncher),
    .ball_at_overflow(ball_at_overflow), .ball_in_feed(ball_in_feed), .rumble(rumble),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock: 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Ticks waiting to be offered, and motor commands waiting to come out
  tick_t      tick_q[$];
  motor_cmd_t cmd_q[$];

  int  mismatches = 0;
  int  ticks_sent = 0;
  int  results_checked = 0;
  int  settings_used = 0;
  int  cycles = 0;
  bit  tick_fired = 1'b0;
  int  burst_left = 1;
  int  gap_left = 0;
  int  hold_left = 0;
  bit  hold_off_done = 1'b0;
  logic [7:0] stall_pat = '0;
  int  pat_age = 0;

  // Mirror of the configuration registers
  logic [sgfc_pkg::TICK_W-1:0]        thr_cfg, hold_cfg, rumble_cfg, ovf_to_cfg, press_cfg;
  logic [sgfc_pkg::VIN_W-1:0]         vin_cfg;
  logic signed [sgfc_pkg::VEL_W-1:0]  vout_cfg, vovf_cfg;

  // Mirror of the controller state
  sgfc_pkg::owner_t                   own_st;
  logic signed [sgfc_pkg::VEL_W-1:0]  spd_st;
  logic                     auto_st, auto_prev_st, ovf_mode, punch_latch, rumble_st;
  logic [sgfc_pkg::TICK_W-1:0]        ovf_cnt, punch_cnt, combo_cnt;
  logic [3:0]               btn_last;

  // Stimulus generator: per-lane level and remaining run length
  bit gen_lvl[8];
  int gen_run[8];

  function automatic logic [sgfc_pkg::TICK_W-1:0] bump(logic [sgfc_pkg::TICK_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic void flip_auto();
    if (auto_st) begin
      auto_prev_st = 1'b1;
      auto_st = 1'b0;
      own_st = sgfc_pkg::OWN_NONE;
    end else begin
      auto_prev_st = 1'b0;
      auto_st = 1'b1;
      own_st = sgfc_pkg::OWN_AUTO;
    end
  endfunction

  // Out and in buttons: edge takes or drops manual ownership, hold sets speed
  function automatic void feed_edge(logic now, logic was,
                                    logic signed [sgfc_pkg::VEL_W-1:0] v);
    if (now != was)
      own_st = now ? sgfc_pkg::OWN_MANUAL : sgfc_pkg::OWN_NONE;
    else if (now)
      spd_st = v;
  endfunction

  function automatic motor_cmd_t feeder_tick(tick_t t);
    motor_cmd_t r;
    logic seen, ov_b, bot_b, top_b, feed_b;
    logic signed [sgfc_pkg::VEL_W-1:0] vin_full;
    int seven_eighths;
    vin_full = $signed({1'b0, vin_cfg});
    seven_eighths = int'(vin_cfg);
    seven_eighths = seven_eighths * 7 / 8;

    // Combo: short press toggles auto, long hold reverses
    if (t.combo != btn_last[0]) begin
      if (!t.combo) begin
        if (combo_cnt <= press_cfg) begin
          flip_auto();
        end else begin
          own_st = sgfc_pkg::OWN_NONE;
          spd_st = '0;
        end
        combo_cnt = '0;
      end
    end else if (t.combo) begin
      if (combo_cnt > press_cfg) begin
        own_st = sgfc_pkg::OWN_MANUAL;
        spd_st = vout_cfg;
      end
      combo_cnt = bump(combo_cnt);
    end
    feed_edge(t.feed_out, btn_last[1], vout_cfg);
    feed_edge(t.feed_in, btn_last[2], vin_full);
    if (t.toggle && !btn_last[3])
      flip_auto();
    btn_last = {t.toggle, t.feed_in, t.feed_out, t.combo};

    // Sensor thresholds and the puncher latch
    seen = t.puncher < thr_cfg;
    if (seen) begin
      punch_cnt = '0;
      punch_latch = 1'b1;
      rumble_st = 1'b0;
    end else begin
      if (punch_cnt > hold_cfg)
        punch_latch = 1'b0;
      else if (punch_cnt > rumble_cfg)
        rumble_st = 1'b1;
      punch_cnt = bump(punch_cnt);
    end
    ov_b = t.overflow < thr_cfg;
    bot_b = t.bottom < thr_cfg;
    top_b = t.top < thr_cfg;
    feed_b = bot_b || top_b;

    // Automatic speed selection
    if (own_st == sgfc_pkg::OWN_AUTO) begin
      if (auto_st) begin
        auto_prev_st = 1'b1;
        if (ovf_mode) begin
          spd_st = vovf_cfg;
          if (ov_b)
            ovf_cnt = '0;
          else if (feed_b || ovf_cnt > ovf_to_cfg)
            ovf_mode = 1'b0;
          else
            ovf_cnt = bump(ovf_cnt);
        end else if (!punch_latch) begin
          spd_st = vin_full;
        end else if (ov_b) begin
          ovf_mode = 1'b1;
          spd_st = vovf_cfg;
        end else if (!top_b) begin
          spd_st = bot_b ? $signed({3'b000, vin_cfg[sgfc_pkg::VIN_W-1:2]})
                         : seven_eighths[sgfc_pkg::VEL_W-1:0];
        end else begin
          spd_st = '0;
        end
      end else if (auto_prev_st) begin
        spd_st = '0;
        auto_prev_st = 1'b0;
      end
    end

    r.velocity = (own_st == sgfc_pkg::OWN_AUTO || own_st == sgfc_pkg::OWN_MANUAL) ?
                 spd_st : '0;
    r.own = own_st;
    r.auto_en = auto_st;
    r.seen = seen;
    r.at_puncher = punch_latch;
    r.at_overflow = ov_b;
    r.in_feed = feed_b;
    r.rumble_on = rumble_st;
    return r;
  endfunction

  // Sensor sample, usually on the chosen side of the threshold, edges included; sometimes fully random
  function automatic logic [SENSOR_W-1:0] level_for(bit ball);
    int r;
    int t;
    r = $urandom_range(0, 9);
    t = int'(thr_cfg);
    if (r == 0 || (ball && t == 0))
      return SENSOR_W'($urandom);
    if (ball)
      return SENSOR_W'((r == 1) ? t - 1 : ((r == 2) ? 0 : $urandom_range(0, t - 1)));
    return SENSOR_W'((r == 1) ? t : ((r == 2) ? 4095 : $urandom_range(t, 4095)));
  endfunction

  function automatic int run_len(int lane, bit on);
    int lp;
    lp = (press_cfg < 30) ? int'(press_cfg) : 30;
    case (lane)
      0: return on ? $urandom_range(1, lp + 4) : $urandom_range(1, 10);
      1, 2: return on ? $urandom_range(1, 6) : $urandom_range(3, 40);
      3: return on ? $urandom_range(1, 3) : $urandom_range(4, 30);
      4: return on ? $urandom_range(1, 6)
                   : $urandom_range(1, (hold_cfg + rumble_cfg < 74) ?
                                        hold_cfg + rumble_cfg + 6 : 80);
      5: return on ? $urandom_range(1, 4)
                   : $urandom_range(1, (ovf_to_cfg < 32) ? ovf_to_cfg + 8 : 40);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  task automatic push_tick(bit c, bit o, bit i, bit tg, int p, int ov, int b, int tp);
    tick_t t;
    t.combo = c;
    t.feed_out = o;
    t.feed_in = i;
    t.toggle = tg;
    t.puncher = SENSOR_W'(p);
    t.overflow = SENSOR_W'(ov);
    t.bottom = SENSOR_W'(b);
    t.top = SENSOR_W'(tp);
    tick_q.push_back(t);
  endtask

  // Mostly coherent button/sensor runs, with some fully random ticks mixed in
  task automatic gen_ticks(int n);
    tick_t t;
    for (int k = 0; k < n; k++) begin
      for (int lane = 0; lane < 8; lane++) begin
        if (gen_run[lane] == 0) begin
          gen_lvl[lane] = !gen_lvl[lane];
          gen_run[lane] = run_len(lane, gen_lvl[lane]);
        end
        gen_run[lane]--;
      end
      if ($urandom_range(0, 9) == 0) begin
        t.combo = 1'($urandom_range(0, 1));
        t.feed_out = 1'($urandom_range(0, 1));
        t.feed_in = 1'($urandom_range(0, 1));
        t.toggle = 1'($urandom_range(0, 1));
        t.puncher = SENSOR_W'($urandom);
        t.overflow = SENSOR_W'($urandom);
        t.bottom = SENSOR_W'($urandom);
        t.top = SENSOR_W'($urandom);
      end else begin
        t.combo = gen_lvl[0];
        t.feed_out = gen_lvl[1];
        t.feed_in = gen_lvl[2];
        t.toggle = gen_lvl[3];
        t.puncher = level_for(gen_lvl[4]);
        t.overflow = level_for(gen_lvl[5]);
        t.bottom = level_for(gen_lvl[6]);
        t.top = level_for(gen_lvl[7]);
      end
      tick_q.push_back(t);
    end
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(sgfc_pkg::reg_index_t idx, int value, bit junk);
    logic [sgfc_pkg::DATA_W-1:0] mask;
    logic [sgfc_pkg::DATA_W-1:0] data;
    case (idx)
      sgfc_pkg::REG_SPEED_IN: mask = 32'h3FF;
      sgfc_pkg::REG_SPEED_OUT, sgfc_pkg::REG_SPEED_OVERFLOW: mask = 32'h7FF;
      default: mask = 32'hFFF;
    endcase
    data = (value & mask) | (junk ? ($urandom & ~mask) : 32'h0);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sgfc_pkg::REG_BALL_THRESHOLD:   thr_cfg = data[sgfc_pkg::TICK_W-1:0];
      sgfc_pkg::REG_PUNCHER_HOLD:     hold_cfg = data[sgfc_pkg::TICK_W-1:0];
      sgfc_pkg::REG_RUMBLE_AFTER:     rumble_cfg = data[sgfc_pkg::TICK_W-1:0];
      sgfc_pkg::REG_OVERFLOW_TIMEOUT: ovf_to_cfg = data[sgfc_pkg::TICK_W-1:0];
      sgfc_pkg::REG_LONG_PRESS:       press_cfg = data[sgfc_pkg::TICK_W-1:0];
      sgfc_pkg::REG_SPEED_IN:         vin_cfg = data[sgfc_pkg::VIN_W-1:0];
      sgfc_pkg::REG_SPEED_OUT:        vout_cfg = data[sgfc_pkg::VEL_W-1:0];
      sgfc_pkg::REG_SPEED_OVERFLOW:   vovf_cfg = data[sgfc_pkg::VEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int thr, int hold, int rum, int ovf, int press,
                            int vin, int vout, int vovf, bit junk);
    write_reg(sgfc_pkg::REG_BALL_THRESHOLD, thr, junk);
    write_reg(sgfc_pkg::REG_PUNCHER_HOLD, hold, junk);
    write_reg(sgfc_pkg::REG_RUMBLE_AFTER, rum, junk);
    write_reg(sgfc_pkg::REG_OVERFLOW_TIMEOUT, ovf, junk);
    write_reg(sgfc_pkg::REG_LONG_PRESS, press, junk);
    write_reg(sgfc_pkg::REG_SPEED_IN, vin, junk);
    write_reg(sgfc_pkg::REG_SPEED_OUT, vout, junk);
    write_reg(sgfc_pkg::REG_SPEED_OVERFLOW, vovf, junk);
    settings_used++;
  endtask

  // Wait until every tick is through and every command has come out
  task automatic drain();
    @(posedge clk);
    while (tick_q.size() != 0 || tick_valid || cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string name, logic signed [11:0] want, logic signed [11:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Driver, sampling side: predict each transfer as it is taken
  always @(posedge clk) begin
    tick_t t;
    tick_fired = 1'b0;
    if (!rst && tick_valid && !tick_stall) begin
      t.combo = combo_button;
      t.feed_out = out_button;
      t.feed_in = in_button;
      t.toggle = toggle_button;
      t.puncher = puncher_level;
      t.overflow = overflow_level;
      t.bottom = bottom_level;
      t.top = top_level;
      cmd_q.push_back(feeder_tick(t));
      tick_fired = 1'b1;
      ticks_sent++;
    end
  end

  // Driver, launch side: hold while offered, else advance in bursts with gaps
  always @(negedge clk) begin
    tick_t t;
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!tick_valid || tick_fired) begin
      if (gap_left > 0) begin
        tick_valid <= 1'b0;
        gap_left--;
      end else if (tick_q.size() != 0) begin
        t = tick_q.pop_front();
        combo_button <= t.combo;
        out_button <= t.feed_out;
        in_button <= t.feed_in;
        toggle_button <= t.toggle;
        puncher_level <= t.puncher;
        overflow_level <= t.overflow;
        bottom_level <= t.bottom;
        top_level <= t.top;
        tick_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: rotating pattern, plus one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (!hold_off_done && results_checked >= HOLD_OFF_AFTER) begin
      hold_off_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      result_stall <= 1'b1;
    end else begin
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom & 32'h7F);
        pat_age = $urandom_range(8, 64);
      end
      result_stall <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
      pat_age--;
    end
  end

  // Monitor: compare each result transfer with the oldest predicted command
  always @(posedge clk) begin
    motor_cmd_t want;
    if (!rst && result_valid && !result_stall) begin
      if (cmd_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no tick outstanding, expected none, got velocity %0d",
                 $time, motor_velocity);
      end else begin
        want = cmd_q.pop_front();
        check_field("motor_velocity", want.velocity, motor_velocity);
        check_field("owner", want.own, owner);
        check_field("auto_enabled", want.auto_en, auto_enabled);
        check_field("ball_seen_puncher", want.seen, ball_seen_puncher);
        check_field("ball_at_puncher", want.at_puncher, ball_at_puncher);
        check_field("ball_at_overflow", want.at_overflow, ball_at_overflow);
        check_field("ball_in_feed", want.in_feed, ball_in_feed);
        check_field("rumble", want.rumble_on, rumble);
        results_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d commands outstanding",
               $time, cycles, cmd_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    // Power-on register values and state
    thr_cfg = sgfc_pkg::BALL_THRESHOLD_RST;
    hold_cfg = sgfc_pkg::PUNCHER_HOLD_RST;
    rumble_cfg = sgfc_pkg::RUMBLE_AFTER_RST;
    ovf_to_cfg = sgfc_pkg::OVERFLOW_TIMEOUT_RST;
    press_cfg = sgfc_pkg::LONG_PRESS_RST;
    vin_cfg = sgfc_pkg::SPEED_IN_RST;
    vout_cfg = sgfc_pkg::SPEED_OUT_RST;
    vovf_cfg = sgfc_pkg::SPEED_OVERFLOW_RST;
    own_st = sgfc_pkg::OWN_NONE;
    spd_st = '0;
    auto_st = 1'b0;
    auto_prev_st = 1'b0;
    ovf_mode = 1'b0;
    punch_latch = 1'b0;
    rumble_st = 1'b0;
    ovf_cnt = '0;
    punch_cnt = '0;
    combo_cnt = '0;
    btn_last = '0;
    for (int k = 0; k < 8; k++) begin
      gen_lvl[k] = 1'b0;
      gen_run[k] = 0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: short timeouts so every path shows up in a few ticks
    set_config(2000, 3, 1, 2, 2, 600, -600, -300, 1'b0);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 0, 0, 0, 0);
    push_tick(0, 0, 0, 0, 1999, 2000, 2000, 1999);
    push_tick(0, 0, 0, 1, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 0, 4095, 0, 4095);
    push_tick(0, 0, 0, 0, 0, 4095, 4095, 0);
    push_tick(0, 0, 0, 0, 0, 0, 4095, 4095);
    repeat (5) push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 1, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 1, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 1, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 1, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(1, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    repeat (5) push_tick(1, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    drain();

    // Random phases over a spread of register settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_config(2000, 250, 100, 100, 10, 600, -600, -300, 1'b0);
        1: set_config(2048, 12, 5, 6, 4, 1023, -1024, 1023, 1'b0);
        2: set_config(0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        3: set_config(4095, 4095, 4095, 4095, 4095, 600, -600, -600, 1'b0);
        default: set_config($urandom_range(500, 3500), $urandom_range(0, 40),
                            $urandom_range(0, 30), $urandom_range(0, 20),
                            $urandom_range(0, 12), $urandom_range(0, 1023),
                            $urandom_range(0, 2047) - 1024,
                            $urandom_range(0, 2047) - 1024, 1'b1);
      endcase
      gen_ticks(TICKS_PER_PHASE);
      drain();
    end

    // Soak: hold combo through a long overflow-mode run
    set_config(2000, 4095, 4095, 4095, 4095, 600, -600, -300, 1'b0);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    drain();
    if (auto_st) begin
      push_tick(0, 0, 0, 1, 4095, 4095, 4095, 4095);
      push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    end
    push_tick(0, 0, 0, 1, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 0, 0, 4095, 4095);
    repeat (SOAK_TICKS) push_tick(1, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    push_tick(0, 0, 0, 0, 4095, 4095, 4095, 4095);
    drain();

    $display("Ran %0d ticks under %0d register settings with bursty input and stalled output,",
             ticks_sent, settings_used);
    $display("including a long hold-off and a long combo hold in overflow mode; %0d checked.",
             results_checked);
    if (mismatches == 0 && cmd_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
